// File: sv/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg: shared types and constants for the sorted region table
// Entry layout, status codes, sequencer states and table sizing.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int unsigned MAX_REGIONS = 16;
  localparam int unsigned IDX_W       = $clog2(MAX_REGIONS);
  localparam int unsigned CNT_W       = $clog2(MAX_REGIONS + 1);
  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned PAGE_SHIFT  = 12;
  localparam int unsigned PG_W        = ADDR_W - PAGE_SHIFT;

  typedef logic [PG_W-1:0] page_t;

  // one table row
  typedef struct packed {
    page_t      start_pg;
    page_t      end_pg;
    page_t      src_pg;
    logic [2:0] rights;
    logic       kind;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_OVERLAP   = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // compare results of the shared evaluation unit
  typedef struct packed {
    logic overlap;
    logic at_or_after;
    logic left_ok;
    logic right_ok;
  } eval_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_RD,
    S_EV,
    S_RD2,
    S_EV2,
    S_INS,
    S_SH_RD,
    S_SH_WR,
    S_WR_NEW,
    S_DONE
  } state_e;

endpackage

// File: sv/srt_ram.sv
// ----------------------------------------------------------------------------
// srt_ram: generic single-port-write, single-port-read RAM
// Registered read data, no reset on contents.
// ----------------------------------------------------------------------------
module srt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/srt_eval.sv
// ----------------------------------------------------------------------------
// srt_eval: shared compare unit
// Checks one table entry against a page range: overlap, order, merge fits.
// ----------------------------------------------------------------------------
module srt_eval (
  input  srt_pkg::entry_t     ent_i,
  input  srt_pkg::page_t      s_i,
  input  srt_pkg::page_t      e_i,
  input  srt_pkg::page_t      src_i,
  input  srt_pkg::page_t      len_i,
  input  logic [2:0]          rights_i,
  input  logic                kind_i,
  output srt_pkg::eval_t      res_o
);
  import srt_pkg::*;

  logic  same;
  page_t ent_len;

  assign same    = (ent_i.rights == rights_i) && (ent_i.kind == kind_i);
  assign ent_len = ent_i.end_pg - ent_i.start_pg;

  always_comb begin
    res_o.overlap = ((ent_i.start_pg <= s_i) && (s_i < ent_i.end_pg)) ||
                    ((s_i <= ent_i.start_pg) && (ent_i.start_pg < e_i));
    res_o.at_or_after = ent_i.start_pg >= e_i;
    // entry starts where the region ends: grow it down
    res_o.left_ok  = (ent_i.start_pg == e_i) && same &&
                     (ent_i.src_pg == (src_i + len_i));
    // entry ends where the region starts: grow it up
    res_o.right_ok = (ent_i.end_pg == s_i) && same &&
                     (src_i == (ent_i.src_pg + ent_len));
  end

endmodule

// File: sv/sorted_region_table_insert_merge.sv
// ----------------------------------------------------------------------------
// sorted_region_table_insert_merge: sorted region table, insert and merge
// One request adds a page-aligned region to a table kept sorted by address.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low; busy_o stays
// high until the result has been shown. The result is on status_o, merged_o
// and entry_count_o for exactly one cycle with done_o high, and must be taken
// then: it is not held. A malformed request goes from the check straight to
// the result. Otherwise the table entries are walked in order, each read
// through the single read port of the entry RAM and held against the region
// by the shared compare unit, until an overlap, a merge, the insertion point
// or the end of the table is found; a right merge reads and checks the
// following entry as well. An inserted region first shifts each later entry
// up one slot, a read and then a write per entry, and is then written in;
// a full table is reported instead.
// ----------------------------------------------------------------------------
module sorted_region_table_insert_merge (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [63:0]                 region_start_i,
  input  logic [63:0]                 region_end_i,
  input  logic [63:0]                 source_addr_i,
  input  logic [2:0]                  access_flags_i,
  input  logic [1:0]                  region_kind_i,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic                        merged_o,
  output logic [srt_pkg::CNT_W-1:0]   entry_count_o
);
  import srt_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] used_q, used_d;
  status_e          status_q, status_d;
  logic             merged_q, merged_d;

  page_t            s_q, e_q, src_q, len_q, len_d;
  logic [2:0]       fl_q;
  logic [1:0]       kd_q;
  logic             misal_q;
  entry_t           hold_q, hold_d;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0] rdata_raw;

  page_t            ev_s;
  eval_t            ev;
  logic             accept;
  logic             malformed;
  logic [CNT_W-1:0] idx_inc, idx_dec;

  assign accept  = start_i && (state_q == S_IDLE);
  assign idx_inc = idx_q + CNT_W'(1);
  assign idx_dec = idx_q - CNT_W'(1);
  assign ram_rdata = entry_t'(rdata_raw);

  // entry storage
  srt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_REGIONS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(rdata_raw)
  );

  // shared compare unit; second pass checks the grown range against the next entry
  assign ev_s = (state_q == S_EV2) ? hold_q.start_pg : s_q;

  srt_eval u_eval (
    .ent_i   (ram_rdata),
    .s_i     (ev_s),
    .e_i     (e_q),
    .src_i   (src_q),
    .len_i   (len_q),
    .rights_i(fl_q),
    .kind_i  (kd_q[0]),
    .res_o   (ev)
  );

  assign malformed = misal_q || !(s_q < e_q) || (fl_q == 3'd0) ||
                     (fl_q[2] && fl_q[1]) || kd_q[1];

  // request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_q     <= region_start_i[63:PAGE_SHIFT];
      e_q     <= region_end_i[63:PAGE_SHIFT];
      src_q   <= source_addr_i[63:PAGE_SHIFT];
      fl_q    <= access_flags_i;
      kd_q    <= region_kind_i;
      misal_q <= (|region_start_i[PAGE_SHIFT-1:0]) |
                 (|region_end_i[PAGE_SHIFT-1:0]) |
                 (|source_addr_i[PAGE_SHIFT-1:0]);
    end
    len_q  <= len_d;
    hold_q <= hold_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      pos_q    <= '0;
      used_q   <= '0;
      status_q <= ST_OK;
      merged_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      pos_q    <= pos_d;
      used_q   <= used_d;
      status_q <= status_d;
      merged_q <= merged_d;
    end
  end

  // next state
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    pos_d    = pos_q;
    used_d   = used_q;
    status_d = status_q;
    merged_d = merged_q;
    len_d    = len_q;
    hold_d   = hold_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_CHK;
      end
      S_CHK: begin
        len_d    = e_q - s_q;
        idx_d    = '0;
        pos_d    = used_q;
        merged_d = 1'b0;
        if (malformed) begin
          status_d = ST_MALFORMED;
          state_d  = S_DONE;
        end else if (used_q == '0) begin
          state_d = S_INS;
        end else begin
          state_d = S_RD;
        end
      end
      S_RD: state_d = S_EV;
      S_EV: begin
        hold_d = ram_rdata;
        if (ev.overlap) begin
          status_d = ST_OVERLAP;
          state_d  = S_DONE;
        end else if (ev.at_or_after) begin
          if (ev.left_ok) begin
            status_d = ST_OK;
            merged_d = 1'b1;
            state_d  = S_DONE;
          end else begin
            pos_d   = idx_q;
            state_d = S_INS;
          end
        end else if (ev.right_ok) begin
          if (idx_inc < used_q) begin
            state_d = S_RD2;
          end else begin
            status_d = ST_OK;
            merged_d = 1'b1;
            state_d  = S_DONE;
          end
        end else if (idx_inc == used_q) begin
          pos_d   = used_q;
          state_d = S_INS;
        end else begin
          idx_d   = idx_inc;
          state_d = S_RD;
        end
      end
      S_RD2: state_d = S_EV2;
      S_EV2: begin
        if (ev.overlap) begin
          status_d = ST_OVERLAP;
        end else begin
          status_d = ST_OK;
          merged_d = 1'b1;
        end
        state_d = S_DONE;
      end
      S_INS: begin
        idx_d = used_q;
        if (used_q >= CNT_W'(MAX_REGIONS)) begin
          status_d = ST_FULL;
          state_d  = S_DONE;
        end else if (used_q == pos_q) begin
          state_d = S_WR_NEW;
        end else begin
          state_d = S_SH_RD;
        end
      end
      S_SH_RD: state_d = S_SH_WR;
      S_SH_WR: begin
        idx_d   = idx_dec;
        state_d = (idx_dec == pos_q) ? S_WR_NEW : S_SH_RD;
      end
      S_WR_NEW: begin
        used_d   = used_q + CNT_W'(1);
        status_d = ST_OK;
        state_d  = S_DONE;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // RAM controls
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q[IDX_W-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx_q[IDX_W-1:0];
    unique case (state_q)
      S_RD2:   ram_raddr = idx_inc[IDX_W-1:0];
      S_SH_RD: ram_raddr = idx_dec[IDX_W-1:0];
      S_EV: begin
        if (!ev.overlap && ev.at_or_after && ev.left_ok) begin
          ram_we             = 1'b1;
          ram_wdata          = ram_rdata;
          ram_wdata.start_pg = s_q;
          ram_wdata.src_pg   = src_q;
        end else if (!ev.overlap && !ev.at_or_after && ev.right_ok &&
                     !(idx_inc < used_q)) begin
          ram_we           = 1'b1;
          ram_wdata        = ram_rdata;
          ram_wdata.end_pg = e_q;
        end
      end
      S_EV2: begin
        ram_we           = !ev.overlap;
        ram_wdata        = hold_q;
        ram_wdata.end_pg = e_q;
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      S_WR_NEW: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[IDX_W-1:0];
        ram_wdata = '{start_pg: s_q, end_pg: e_q, src_pg: src_q,
                      rights: fl_q, kind: kd_q[0]};
      end
      default: ;
    endcase
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = (state_q == S_DONE);
  assign status_o      = status_q;
  assign merged_o      = merged_q;
  assign entry_count_o = used_q;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o) else $error("busy not raised after request");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(MAX_REGIONS)) else $error("entry count beyond table size");
  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result shown for more than one cycle");
  a_merge_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && merged_o) |-> (status_q == ST_OK)) else $error("merge with error status");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |-> ($past(state_q) == S_WR_NEW))
    else $error("entry count changed outside insertion");
`endif

endmodule

// File: bench/sorted_region_table_insert_merge_test.sv
// ----------------------------------------------------------------------------
// sorted_region_table_insert_merge_test: bench for the sorted region table
// Drives region requests with random gaps, predicts status, merge flag and
// entry count from a behavioral table, and checks every result beat in order.
// ----------------------------------------------------------------------------
module sorted_region_table_insert_merge_test;
  import srt_pkg::*;

  localparam int unsigned MAXR = MAX_REGIONS;
  localparam logic [63:0] PAGE = 64'h1000;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [63:0]         region_start_i;
  logic [63:0]         region_end_i;
  logic [63:0]         source_addr_i;
  logic [2:0]          access_flags_i;
  logic [1:0]          region_kind_i;
  logic                done_o;
  logic [1:0]          status_o;
  logic                merged_o;
  logic [CNT_W-1:0]    entry_count_o;

  sorted_region_table_insert_merge DUT (.*);

  // result of one request
  typedef struct packed {
    status_e          status;
    logic             merged;
    logic [CNT_W-1:0] count;
  } verdict_t;

  // shadow copy of the table
  page_t       tbl_start [MAXR];
  page_t       tbl_end   [MAXR];
  page_t       tbl_src   [MAXR];
  logic [2:0]  tbl_rights[MAXR];
  logic        tbl_kind  [MAXR];
  int unsigned tbl_used;

  verdict_t    pending_verdicts[$];
  int unsigned n_sent, n_checked, n_errors;
  int unsigned n_merged, n_full, n_overlap, n_bad;

  // clock
  always begin
    clk_i = 1'b0; #5;
    clk_i = 1'b1; #5;
  end

  initial begin
    #20000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic bit pages_overlap(page_t a0, page_t a1, page_t b0, page_t b1);
    return (a0 <= b0 && b0 < a1) || (b0 <= a0 && a0 < b1);
  endfunction

  // table update and expected verdict for one request
  function automatic verdict_t region_insert_verdict(logic [63:0] sa, logic [63:0] ea,
                                                     logic [63:0] ra, logic [2:0] fl,
                                                     logic [1:0] kd);
    verdict_t    v;
    page_t       s, e, src, len, es, ee, esrc;
    int unsigned pos;
    bit          same;
    v = '{status: ST_OK, merged: 1'b0, count: '0};
    if (sa[11:0] != 0 || ea[11:0] != 0 || ra[11:0] != 0 || !(sa < ea) || fl == 0
        || (fl[2] && fl[1]) || kd > 1) begin
      v.status = ST_MALFORMED;
      v.count  = CNT_W'(tbl_used);
      return v;
    end
    s = sa[63:12]; e = ea[63:12]; src = ra[63:12]; len = e - s;
    pos = tbl_used;
    for (int unsigned i = 0; i < tbl_used; i++) begin
      es = tbl_start[i]; ee = tbl_end[i]; esrc = tbl_src[i];
      same = tbl_rights[i] == fl && tbl_kind[i] == kd[0];
      if (pages_overlap(es, ee, s, e)) begin
        v.status = ST_OVERLAP; v.count = CNT_W'(tbl_used); return v;
      end
      if (es >= e) begin
        if (es == e && same && esrc == page_t'(src + len)) begin
          tbl_start[i] = s; tbl_src[i] = src;
          v.merged = 1'b1; v.count = CNT_W'(tbl_used); return v;
        end
        pos = i;
        break;
      end
      if (ee == s && same && src == page_t'(esrc + (ee - es))) begin
        if (i + 1 < tbl_used && pages_overlap(es, e, tbl_start[i+1], tbl_end[i+1])) begin
          v.status = ST_OVERLAP; v.count = CNT_W'(tbl_used); return v;
        end
        tbl_end[i] = e;
        v.merged = 1'b1; v.count = CNT_W'(tbl_used); return v;
      end
    end
    if (tbl_used >= MAXR) begin
      v.status = ST_FULL; v.count = CNT_W'(tbl_used); return v;
    end
    for (int unsigned i = tbl_used; i > pos; i--) begin
      tbl_start[i] = tbl_start[i-1]; tbl_end[i] = tbl_end[i-1];
      tbl_src[i] = tbl_src[i-1]; tbl_rights[i] = tbl_rights[i-1];
      tbl_kind[i] = tbl_kind[i-1];
    end
    tbl_start[pos] = s; tbl_end[pos] = e; tbl_src[pos] = src;
    tbl_rights[pos] = fl; tbl_kind[pos] = kd[0];
    tbl_used++;
    v.count = CNT_W'(tbl_used);
    return v;
  endfunction

  // send one request beat, with a random lead-in gap
  task automatic send_region(logic [63:0] sa, logic [63:0] ea, logic [63:0] ra,
                             logic [2:0] fl, logic [1:0] kd);
    verdict_t v;
    repeat ($urandom_range(0, 7)) @(negedge clk_i);
    start_i = 1'b1;
    region_start_i = sa; region_end_i = ea; source_addr_i = ra;
    access_flags_i = fl; region_kind_i = kd;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    v = region_insert_verdict(sa, ea, ra, fl, kd);
    pending_verdicts.push_back(v);
    if (v.merged) n_merged++;
    case (v.status)
      ST_FULL:      n_full++;
      ST_OVERLAP:   n_overlap++;
      ST_MALFORMED: n_bad++;
      default: ;
    endcase
    n_sent++;
    @(negedge clk_i);
    start_i = 1'b0;
  endtask

  task automatic drain_results();
    while (pending_verdicts.size() != 0) @(negedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && done_o) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result beat status=%0d", $time, status_o);
        n_errors++;
      end else begin
        want = pending_verdicts.pop_front();
        n_checked++;
        if (status_o != want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          n_errors++;
        end
        if (merged_o != want.merged) begin
          $display("%0t: merged expected %0d actual %0d", $time, want.merged, merged_o);
          n_errors++;
        end
        if (entry_count_o != want.count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                   entry_count_o);
          n_errors++;
        end
      end
    end
  end

  function automatic logic [63:0] pg(longint unsigned p);
    return p << 12;
  endfunction

  // malformed requests and field extremes
  task automatic test_malformed();
    send_region(64'h1, PAGE*2, '0, 3'd1, 2'd0);
    send_region('0, PAGE*2 + 64'h800, '0, 3'd1, 2'd0);
    send_region('0, PAGE, 64'hFFF, 3'd1, 2'd0);
    send_region(PAGE, PAGE, '0, 3'd1, 2'd0);
    send_region(PAGE*2, PAGE, '0, 3'd1, 2'd0);
    send_region('0, PAGE, '0, 3'd0, 2'd0);
    send_region('0, PAGE, '0, 3'd6, 2'd0);
    send_region('0, PAGE, '0, 3'd7, 2'd1);
    send_region('0, PAGE, '0, 3'd1, 2'd2);
    send_region('0, PAGE, '0, 3'd1, 2'd3);
    send_region(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, '1, 3'd7, 2'd3);
  endtask

  // insert, overlap, left merge, right merge that overlaps the next entry, touching insert, top of address space
  task automatic test_merges();
    send_region(pg(100), pg(110), pg(500), 3'd3, 2'd0);
    send_region(pg(105), pg(108), pg(0), 3'd3, 2'd0);
    send_region(pg(90), pg(100), pg(490), 3'd3, 2'd0);
    send_region(pg(110), pg(120), pg(520), 3'd3, 2'd0);
    send_region(pg(120), pg(125), pg(0), 3'd5, 2'd1);
    send_region(pg(80), pg(90), pg(0), 3'd1, 2'd0);
    send_region(pg(130), pg(140), pg(0), 3'd1, 2'd1);
    send_region(pg(125), pg(135), pg(5), 3'd5, 2'd1);
    send_region(64'hFFFF_FFFF_FFFF_E000, 64'hFFFF_FFFF_FFFF_F000,
                64'hFFFF_FFFF_FFFF_F000, 3'd4, 2'd1);
    send_region('0, PAGE, '0, 3'd4, 2'd1);
    drain_results();
  endtask

  // fill to full, then check full and merge on a full table
  task automatic test_full_table();
    for (int i = 0; i < 18; i++)
      send_region(pg(1000 + 4*i), pg(1001 + 4*i), pg(7000 + 8*i), 3'd2, 2'd1);
    send_region(pg(1001), pg(1002), pg(7001), 3'd2, 2'd1);
    drain_results();
    repeat (100) @(negedge clk_i);
  endtask

  // random runs on fresh address windows: mostly well-formed, nearby addresses
  task automatic test_random(int unsigned items);
    logic [63:0] sa, ea, ra;
    logic [2:0]  fl;
    logic [1:0]  kd;
    longint unsigned base, s, l;
    base = 64'd2000;
    for (int unsigned k = 0; k < items; k++) begin
      if (k % 200 == 199) begin
        // spread to a fresh address window; table stays full of old entries
        base = {$urandom, $urandom} >> 13;
      end
      s  = base + $urandom_range(0, 60);
      l  = $urandom_range(1, 6);
      sa = pg(s); ea = pg(s + l);
      ra = pg($urandom_range(0, 3) == 0 ? {$urandom, $urandom} : 64'd3000 + s);
      fl = 3'($urandom_range(0, 3) == 0 ? 3'd3 : $urandom_range(1, 5));
      kd = 2'($urandom_range(0, 7) == 0 ? 2'($urandom) : 2'($urandom_range(0, 1)));
      case ($urandom_range(0, 19))
        0: sa = {$urandom, $urandom};
        1: ea = {$urandom, $urandom};
        2: ra = {$urandom, $urandom};
        3: fl = 3'($urandom);
        default: ;
      endcase
      send_region(sa, ea, ra, fl, kd);
      if (k == items / 2) drain_results();
    end
  endtask

  initial begin
    n_sent = 0; n_checked = 0; n_errors = 0;
    n_merged = 0; n_full = 0; n_overlap = 0; n_bad = 0;
    tbl_used = 0;
    rst_ni = 1'b0; start_i = 1'b0;
    region_start_i = '0; region_end_i = '0; source_addr_i = '0;
    access_flags_i = '0; region_kind_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_malformed();
    test_merges();
    test_full_table();
    test_random(1500);
    drain_results();
    repeat (100) @(negedge clk_i);
    $display("Run covered %0d requests, %0d results checked: %0d merged, %0d overlap,",
             n_sent, n_checked, n_merged, n_overlap);
    $display("  %0d table full, %0d malformed, %0d mismatches.", n_full, n_bad, n_errors);
    if (n_errors == 0 && pending_verdicts.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
